FILE: design/scrt_pkg.sv
`default_nettype none

package scrt_pkg;

    // Default geometry of the tag store.
    localparam int unsigned DEF_MAX_SET_BITS = 6;
    localparam int unsigned DEF_MAX_WAYS     = 8;

    // Field widths of one stored line.
    localparam int unsigned TAG_W   = 62;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned USES_W  = 32;
    localparam int unsigned PRIO_W  = 8;
    localparam int unsigned LINE_W  = 1 + TAG_W + STAMP_W + USES_W + PRIO_W;

    // Beat widths and the configuration port.
    localparam int unsigned ADDR_W     = 64;
    localparam int unsigned NOW_W      = 32;
    localparam int unsigned TOTAL_W    = 32;
    localparam int unsigned S_DATA_W   = 96;
    localparam int unsigned M_DATA_W   = 104;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 6;

    // Replacement score weights and line constants.
    localparam int unsigned PRIO_WEIGHT = 1000;
    localparam int unsigned AGE_WEIGHT  = 10;
    localparam logic [PRIO_W-1:0] PRIO_MAX  = 8'd255;
    localparam logic [PRIO_W-1:0] PRIO_FILL = 8'd10;

    // Quotient width of the shared divider.
    localparam int unsigned QUOT_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS   = 2'd0,
        CFG_BLOCK_BITS = 2'd1,
        CFG_WAYS       = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic                valid;
        logic [TAG_W-1:0]    tag;
        logic [STAMP_W-1:0]  stamp;
        logic [USES_W-1:0]   uses;
        logic [PRIO_W-1:0]   prio;
    } line_t;

    typedef struct packed {
        logic              start;
        logic [USES_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LK_RD,
        ST_LK_CHK,
        ST_SC_RD,
        ST_SC_LD,
        ST_SC_DIV,
        ST_SC_CMP,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

FILE: design/scrt_ram.sv
`default_nettype none

module scrt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/scrt_div.sv
`default_nettype none

module scrt_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire scrt_pkg::div_req_t req,
    output scrt_pkg::div_rsp_t      rsp
);

    import scrt_pkg::*;

    localparam int unsigned CNT_W = $clog2(QUOT_W);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [USES_W-1:0] dvs_reg;
    logic [USES_W-1:0] rem_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic              done_reg;
    logic [USES_W:0]   trial;
    logic              take;

    // Restoring step: the dividend is all ones, so a one shifts in each cycle.
    always_comb begin
        trial = {rem_reg, 1'b1};
        take  = (trial >= {1'b0, dvs_reg});
    end

    // Control of the iteration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QUOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient, one bit per cycle.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvs_reg  <= req.divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= take ? USES_W'(trial - {1'b0, dvs_reg}) : trial[USES_W-1:0];
            quot_reg <= {quot_reg[QUOT_W-2:0], take};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

`default_nettype wire

FILE: design/score_replacement_cache_tags_unit.sv
`default_nettype none
// Sequence: a hit reads and checks the ways of the set in turn until the tag matches; a miss into a
// free way needs no scoring; a miss into a full set scores every way in use (64-step shared divider).
// One item at a time: a new beat is taken only after the previous result is loaded for output.
// Reset: synchronous; afterwards a clearing pass writes every line, one per cycle
// (2^MAX_SET_BITS * MAX_WAYS lines, 512 by default), before the first beat is taken.
module score_replacement_cache_tags_unit #(
    parameter int unsigned MAX_SET_BITS = scrt_pkg::DEF_MAX_SET_BITS,
    parameter int unsigned MAX_WAYS     = scrt_pkg::DEF_MAX_WAYS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wen,
    input  wire logic [scrt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [scrt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // address [63:0], now [95:64]
    input  wire logic [scrt_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // hit [0], evicted [1], way [4:2], hit_total [36:5], miss_total [68:37],
    // evict_total [100:69], zero [103:101]
    output logic [scrt_pkg::M_DATA_W-1:0]          m_tdata
);

    import scrt_pkg::*;

    localparam int unsigned DEPTH = (1 << MAX_SET_BITS) * MAX_WAYS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int unsigned NW_W  = $clog2(MAX_WAYS + 1);
    localparam int unsigned SB_W  = $clog2(MAX_SET_BITS + 1);
    localparam int unsigned PART_W = 38;

    state_t state_reg, state_next;

    logic [2:0]              set_bits_reg;
    logic [5:0]              block_bits_reg;
    logic [3:0]              ways_reg;

    logic [MAX_SET_BITS-1:0] set_reg;
    logic [TAG_W-1:0]        tag_reg;
    logic [NOW_W-1:0]        now_reg;
    logic [NW_W-1:0]         nw_reg;
    logic [WAY_W-1:0]        way_reg;
    logic [WAY_W-1:0]        target_reg;
    logic                    hit_reg;
    logic                    evict_reg;
    logic                    free_reg;
    logic [WAY_W-1:0]        free_way_reg;
    line_t                   line_reg;
    logic [PART_W-1:0]       part_reg;
    logic [QUOT_W-1:0]       best_reg;
    logic [AW-1:0]           clr_reg;
    logic [TOTAL_W-1:0]      hits_reg, misses_reg, evicts_reg;
    logic                    m_valid_reg;
    logic [M_DATA_W-1:0]     m_data_reg;

    // Field decode of the incoming beat.
    logic [ADDR_W-1:0]       s_addr;
    logic [NOW_W-1:0]        s_now;
    logic [SB_W-1:0]         sb_eff;
    logic [6:0]              shift_amt;
    logic [ADDR_W-1:0]       addr_sh;
    logic [MAX_SET_BITS-1:0] set_in;
    logic [TAG_W-1:0]        tag_in;
    logic [NW_W-1:0]         nw_in;

    always_comb begin
        s_addr  = s_tdata[ADDR_W-1:0];
        s_now   = s_tdata[S_DATA_W-1:ADDR_W];
        sb_eff  = (int'(set_bits_reg) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS)
                                                      : SB_W'(set_bits_reg);
        shift_amt = 7'(sb_eff) + 7'(block_bits_reg);
        addr_sh   = s_addr >> block_bits_reg;
        for (int i = 0; i < MAX_SET_BITS; i++) begin
            set_in[i] = addr_sh[i] & (i < int'(sb_eff));
        end
        tag_in = (shift_amt >= 7'd64) ? '0 : TAG_W'(s_addr >> shift_amt);
        if (ways_reg == 4'd0) begin
            nw_in = NW_W'(1);
        end else if (int'(ways_reg) > MAX_WAYS) begin
            nw_in = NW_W'(MAX_WAYS);
        end else begin
            nw_in = NW_W'(ways_reg);
        end
    end

    // Shared pieces of the sequencer.
    logic          last_way;
    logic          fin_go;
    logic [AW-1:0] way_addr;
    line_t         rd_line;
    logic [LINE_W-1:0] rdata;
    logic          tag_match;

    always_comb begin
        last_way  = (NW_W'(way_reg) == nw_reg - NW_W'(1));
        fin_go    = !m_valid_reg || m_tready;
        way_addr  = AW'(set_reg * MAX_WAYS) + AW'(way_reg);
        rd_line   = line_t'(rdata);
        tag_match = rd_line.valid && (rd_line.tag == tag_reg);
    end

    // Memory and divider hookup.
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    line_t             ram_wline;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    scrt_ram #(
        .WIDTH(LINE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wline),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(rdata)
    );

    scrt_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (s_tvalid) state_next = ST_LK_RD;
            ST_LK_RD:  state_next = ST_LK_CHK;
            ST_LK_CHK: begin
                if (tag_match) begin
                    state_next = ST_FIN;
                end else if (last_way) begin
                    state_next = (free_reg || !rd_line.valid) ? ST_FIN : ST_SC_RD;
                end else begin
                    state_next = ST_LK_RD;
                end
            end
            ST_SC_RD:  state_next = ST_SC_LD;
            ST_SC_LD:  state_next = ST_SC_DIV;
            ST_SC_DIV: if (div_rsp.done) state_next = ST_SC_CMP;
            ST_SC_CMP: state_next = last_way ? ST_FIN : ST_SC_RD;
            ST_FIN:    if (fin_go) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_tready        = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = way_addr;
        ram_raddr       = way_addr;
        ram_wline       = '0;
        div_req.start   = 1'b0;
        div_req.divisor = rd_line.uses;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
            end
            ST_IDLE:  s_tready = 1'b1;
            ST_LK_RD, ST_SC_RD: ram_re = 1'b1;
            ST_SC_LD: div_req.start = 1'b1;
            ST_FIN: begin
                ram_we          = fin_go;
                ram_waddr       = AW'(set_reg * MAX_WAYS) + AW'(target_reg);
                ram_wline.valid = 1'b1;
                ram_wline.tag   = tag_reg;
                ram_wline.stamp = now_reg;
                if (hit_reg) begin
                    ram_wline.uses = (&line_reg.uses) ? line_reg.uses
                                                      : line_reg.uses + USES_W'(1);
                    ram_wline.prio = (line_reg.prio == PRIO_MAX) ? PRIO_MAX
                                                                 : line_reg.prio + PRIO_W'(1);
                end else begin
                    ram_wline.uses = USES_W'(1);
                    ram_wline.prio = PRIO_FILL;
                end
            end
            default: ;
        endcase
    end

    // Score of the way in hand: quotient plus the registered weighted terms.
    logic [QUOT_W:0]   score_sum;
    logic [QUOT_W-1:0] score;
    logic [STAMP_W-1:0] age;

    always_comb begin
        score_sum = {1'b0, div_rsp.quot} + (QUOT_W+1)'(part_reg);
        score     = score_sum[QUOT_W] ? '1 : score_sum[QUOT_W-1:0];
        age       = (now_reg >= rd_line.stamp) ? now_reg - rd_line.stamp : '0;
    end

    // Result beat packing.
    logic [WAY_W+2:0] way_ext;
    logic [TOTAL_W-1:0] hits_out, misses_out, evicts_out;

    always_comb begin
        way_ext    = {3'b000, target_reg};
        hits_out   = (hit_reg && !(&hits_reg)) ? hits_reg + TOTAL_W'(1) : hits_reg;
        misses_out = (!hit_reg && !(&misses_reg)) ? misses_reg + TOTAL_W'(1) : misses_reg;
        evicts_out = (evict_reg && !(&evicts_reg)) ? evicts_reg + TOTAL_W'(1) : evicts_reg;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            set_bits_reg   <= 3'd1;
            block_bits_reg <= 6'd1;
            ways_reg       <= 4'd1;
            hits_reg       <= '0;
            misses_reg     <= '0;
            evicts_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cfg_wen) begin
                unique case (cfg_index)
                    CFG_SET_BITS:   set_bits_reg   <= cfg_wdata[2:0];
                    CFG_BLOCK_BITS: block_bits_reg <= cfg_wdata[5:0];
                    CFG_WAYS:       ways_reg       <= cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_FIN && fin_go) begin
                m_valid_reg <= 1'b1;
                hits_reg    <= hits_out;
                misses_reg  <= misses_out;
                evicts_reg  <= evicts_out;
            end
        end
    end

    // Item registers and the search.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                set_reg    <= set_in;
                tag_reg    <= tag_in;
                now_reg    <= s_now;
                nw_reg     <= nw_in;
                way_reg    <= '0;
                free_reg   <= 1'b0;
                hit_reg    <= 1'b0;
                evict_reg  <= 1'b0;
            end
            ST_LK_CHK: begin
                line_reg <= rd_line;
                if (tag_match) begin
                    hit_reg    <= 1'b1;
                    target_reg <= way_reg;
                end else begin
                    if (!rd_line.valid && !free_reg) begin
                        free_reg     <= 1'b1;
                        free_way_reg <= way_reg;
                    end
                    if (last_way) begin
                        if (free_reg) begin
                            target_reg <= free_way_reg;
                        end else if (!rd_line.valid) begin
                            target_reg <= way_reg;
                        end else begin
                            target_reg <= '0;
                            evict_reg  <= 1'b1;
                            best_reg   <= '0;
                        end
                        way_reg <= '0;
                    end else begin
                        way_reg <= way_reg + WAY_W'(1);
                    end
                end
            end
            ST_SC_LD: begin
                part_reg <= PART_W'(rd_line.prio * PRIO_WEIGHT)
                          + PART_W'(age) * PART_W'(AGE_WEIGHT);
            end
            ST_SC_CMP: begin
                if (score > best_reg) begin
                    best_reg   <= score;
                    target_reg <= way_reg;
                end
                way_reg <= way_reg + WAY_W'(1);
            end
            ST_FIN: begin
                if (fin_go) begin
                    m_data_reg <= {3'b000, evicts_out, misses_out, hits_out,
                                   way_ext[2:0], evict_reg, hit_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // The line store is written only by the clearing pass and at the end of an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_FIN))
        else $error("line store written outside clear or finish");

    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_SC_DIV))
        else $error("divider finished while not awaited");

    // A hit never reports an eviction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg[0] && m_data_reg[1]))
        else $error("hit reported together with an eviction");

    // The hit total never falls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> hits_reg >= $past(hits_reg))
        else $error("hit total decreased");

endmodule

`default_nettype wire
